FILE: src/yuvc_pkg.sv
// Shared types, constants and helper functions for the NV12 to ARGB converter.
package yuvc_pkg;

   localparam int MAX_DIMENSION = 4096;
   localparam int COUNT_WIDTH   = $clog2(MAX_DIMENSION);
   localparam int DIM_WIDTH     = 13;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int QUEUE_DEPTH   = 2;
   localparam int QUEUE_PTR_WIDTH   = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_COUNT_WIDTH = $clog2(QUEUE_DEPTH + 1);
   localparam int SUM_WIDTH     = 11;

   localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
   localparam logic [7:0] CHANNEL_MAX  = 8'd255;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_FRAME_WIDTH  = 2'd0,
      CSR_FRAME_HEIGHT = 2'd1,
      CSR_SPARE_2      = 2'd2,
      CSR_SPARE_3      = 2'd3
   } csr_index_type;

   // One classified pixel on its way from the front end to the back end.
   typedef struct packed {
      logic [7:0]        luma;
      logic signed [7:0] blue_diff;
      logic signed [7:0] red_diff;
      logic              row_end;
      logic              frame_end;
   } item_type;

   // Handshake between the queue and either of its neighbours.
   typedef struct packed {
      logic valid;
      logic ready;
   } link_type;

   // Raw chroma byte to signed offset: raw-128 below 128, raw-129 otherwise.
   function automatic logic signed [7:0] chroma_of(input logic [7:0] raw);
      logic [7:0] flipped;
      flipped = raw ^ 8'h80;
      return $signed(flipped - {7'd0, raw[7]});
   endfunction

   // Raw luma byte: used as is below 128, otherwise one less.
   function automatic logic [7:0] luma_of(input logic [7:0] raw);
      return raw - {7'd0, raw[7]};
   endfunction

endpackage

FILE: src/yuvc_front.sv
// Front end: configuration registers, pixel position counters and chroma hold.
module yuvc_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [7:0]                           req_luma_byte,
   input  logic [7:0]                           req_blue_diff_byte,
   input  logic [7:0]                           req_red_diff_byte,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [yuvc_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [yuvc_pkg::DIM_WIDTH-1:0]       csr_data,
   input  yuvc_pkg::link_type                   push_link_in,
   output logic                                 push_valid,
   output yuvc_pkg::item_type                   push_item
);

   logic [yuvc_pkg::DIM_WIDTH-1:0]   frame_width_ff, frame_width_in;
   logic [yuvc_pkg::DIM_WIDTH-1:0]   frame_height_ff, frame_height_in;
   logic [yuvc_pkg::COUNT_WIDTH-1:0] column_count_ff, column_count_in;
   logic [yuvc_pkg::COUNT_WIDTH-1:0] row_count_ff, row_count_in;
   logic [7:0]                       held_blue_diff_ff, held_blue_diff_in;
   logic [7:0]                       held_red_diff_ff, held_red_diff_in;
   logic [yuvc_pkg::COUNT_WIDTH-1:0] column_last;
   logic [yuvc_pkg::COUNT_WIDTH-1:0] row_last;
   logic                             last_col;
   logic                             last_row;
   logic                             accept;
   logic [7:0]                       blue_raw;
   logic [7:0]                       red_raw;

   // Last valid position for a dimension, after clamping it to 2..MAX_DIMENSION.
   function automatic logic [yuvc_pkg::COUNT_WIDTH-1:0] last_of(
      input logic [yuvc_pkg::DIM_WIDTH-1:0] dim);
      logic [yuvc_pkg::DIM_WIDTH:0] clamped;
      clamped = {1'b0, dim};
      if (dim < yuvc_pkg::DIM_WIDTH'(2)) begin
         clamped = (yuvc_pkg::DIM_WIDTH+1)'(2);
      end else if ({1'b0, dim} > (yuvc_pkg::DIM_WIDTH+1)'(yuvc_pkg::MAX_DIMENSION)) begin
         clamped = (yuvc_pkg::DIM_WIDTH+1)'(yuvc_pkg::MAX_DIMENSION);
      end
      return yuvc_pkg::COUNT_WIDTH'(clamped - (yuvc_pkg::DIM_WIDTH+1)'(1));
   endfunction

   assign csr_ready  = 1'b1;
   assign req_stall  = !push_link_in.ready;
   assign accept     = req_valid && push_link_in.ready;
   assign push_valid = accept;

   assign column_last = last_of(frame_width_ff);
   assign row_last    = last_of(frame_height_ff);
   assign last_col    = column_count_ff >= column_last;
   assign last_row    = row_count_ff >= row_last;

   // Even columns take the chroma pair from the transaction, odd ones reuse it.
   assign blue_raw = column_count_ff[0] ? held_blue_diff_ff : req_blue_diff_byte;
   assign red_raw  = column_count_ff[0] ? held_red_diff_ff  : req_red_diff_byte;

   always_comb begin
      push_item.luma      = yuvc_pkg::luma_of(req_luma_byte);
      push_item.blue_diff = yuvc_pkg::chroma_of(blue_raw);
      push_item.red_diff  = yuvc_pkg::chroma_of(red_raw);
      push_item.row_end   = last_col;
      push_item.frame_end = last_col && last_row;
   end

   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      if (csr_valid) begin
         unique case (yuvc_pkg::csr_index_type'(csr_index))
            yuvc_pkg::CSR_FRAME_WIDTH:  frame_width_in  = csr_data;
            yuvc_pkg::CSR_FRAME_HEIGHT: frame_height_in = csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      column_count_in   = column_count_ff;
      row_count_in      = row_count_ff;
      held_blue_diff_in = held_blue_diff_ff;
      held_red_diff_in  = held_red_diff_ff;
      if (accept) begin
         held_blue_diff_in = blue_raw;
         held_red_diff_in  = red_raw;
         if (last_col) begin
            column_count_in = '0;
            row_count_in    = last_row ? '0 : row_count_ff + 1'b1;
         end else begin
            column_count_in = column_count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff    <= yuvc_pkg::DIM_WIDTH'(640);
         frame_height_ff   <= yuvc_pkg::DIM_WIDTH'(480);
         column_count_ff   <= '0;
         row_count_ff      <= '0;
         held_blue_diff_ff <= '0;
         held_red_diff_ff  <= '0;
      end else begin
         frame_width_ff    <= frame_width_in;
         frame_height_ff   <= frame_height_in;
         column_count_ff   <= column_count_in;
         row_count_ff      <= row_count_in;
         held_blue_diff_ff <= held_blue_diff_in;
         held_red_diff_ff  <= held_red_diff_in;
      end
   end

endmodule

FILE: src/yuvc_queue.sv
// Short queue of classified pixels between the front end and the back end.
module yuvc_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   input  yuvc_pkg::item_type push_item,
   output yuvc_pkg::link_type push_link,
   output yuvc_pkg::link_type pop_link,
   input  logic               pop_ready,
   output yuvc_pkg::item_type pop_item
);

   yuvc_pkg::item_type                     entry_ff [yuvc_pkg::QUEUE_DEPTH];
   logic [yuvc_pkg::QUEUE_PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [yuvc_pkg::QUEUE_PTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [yuvc_pkg::QUEUE_COUNT_WIDTH-1:0] count_ff, count_in;
   logic                                   do_push;
   logic                                   do_pop;

   function automatic logic [yuvc_pkg::QUEUE_PTR_WIDTH-1:0] bump(
      input logic [yuvc_pkg::QUEUE_PTR_WIDTH-1:0] ptr);
      if (ptr == yuvc_pkg::QUEUE_PTR_WIDTH'(yuvc_pkg::QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return ptr + 1'b1;
   endfunction

   assign push_link.valid = push_valid;
   assign push_link.ready = count_ff != yuvc_pkg::QUEUE_COUNT_WIDTH'(yuvc_pkg::QUEUE_DEPTH);
   assign pop_link.valid  = count_ff != '0;
   assign pop_link.ready  = pop_ready;
   assign pop_item        = entry_ff[rd_ptr_ff];

   assign do_push = push_valid && push_link.ready;
   assign do_pop  = pop_link.valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? bump(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? bump(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

FILE: src/yuvc_back.sv
// Back end: shift-add colour conversion, clamping and the output register.
module yuvc_back (
   input  logic               clock,
   input  logic               reset,
   input  yuvc_pkg::link_type pop_link,
   input  yuvc_pkg::item_type pop_item,
   output logic               pop_ready,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [31:0]        rsp_argb_word,
   output logic               rsp_row_end,
   output logic               rsp_frame_end
);

   logic                                    rsp_valid_ff, rsp_valid_in;
   logic [31:0]                             argb_word_ff;
   logic                                    row_end_ff;
   logic                                    frame_end_ff;
   logic signed [yuvc_pkg::SUM_WIDTH-1:0]   luma_ext;
   logic signed [yuvc_pkg::SUM_WIDTH-1:0]   cb_ext;
   logic signed [yuvc_pkg::SUM_WIDTH-1:0]   cr_ext;
   logic signed [yuvc_pkg::SUM_WIDTH-1:0]   red_sum;
   logic signed [yuvc_pkg::SUM_WIDTH-1:0]   green_sum;
   logic signed [yuvc_pkg::SUM_WIDTH-1:0]   blue_sum;
   logic                                    load;

   function automatic logic [7:0] clamp8(input logic signed [yuvc_pkg::SUM_WIDTH-1:0] v);
      if (v < 0) begin
         return 8'd0;
      end else if (v > $signed({3'd0, yuvc_pkg::CHANNEL_MAX})) begin
         return yuvc_pkg::CHANNEL_MAX;
      end
      return v[7:0];
   endfunction

   assign luma_ext = $signed({3'd0, pop_item.luma});
   assign cb_ext   = yuvc_pkg::SUM_WIDTH'(pop_item.blue_diff);
   assign cr_ext   = yuvc_pkg::SUM_WIDTH'(pop_item.red_diff);

   // Arithmetic right shifts give the floor of each fractional weight.
   assign red_sum   = luma_ext + cr_ext + (cr_ext >>> 2) + (cr_ext >>> 3) + (cr_ext >>> 5);
   assign green_sum = luma_ext - (cb_ext >>> 2) + (cb_ext >>> 4) + (cb_ext >>> 5)
                      - (cr_ext >>> 1) + (cr_ext >>> 3) + (cr_ext >>> 4) + (cr_ext >>> 5);
   assign blue_sum  = luma_ext + cb_ext + (cb_ext >>> 1) + (cb_ext >>> 2) + (cb_ext >>> 6);

   // The output register refills whenever it is empty or being emptied.
   assign pop_ready = !rsp_valid_ff || !rsp_stall;
   assign load      = pop_link.valid && pop_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (pop_ready) begin
         rsp_valid_in = pop_link.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         argb_word_ff <= {yuvc_pkg::ALPHA_OPAQUE, clamp8(red_sum), clamp8(green_sum),
                          clamp8(blue_sum)};
         row_end_ff   <= pop_item.row_end;
         frame_end_ff <= pop_item.frame_end;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_argb_word = argb_word_ff;
   assign rsp_row_end   = row_end_ff;
   assign rsp_frame_end = frame_end_ff;

endmodule

FILE: src/yuv420sp_to_argb_converter.sv
// Top level of the NV12 to opaque ARGB pixel converter.
// Pixels enter in raster order, one transaction per clock while req_stall is low, and
// each gives one ARGB word via the queue and the output register, with flags for the last
// pixel of a row and of a frame. The chroma pair is taken on even columns and reused on
// the following odd column. A two-entry queue sits between the front end (counters, chroma
// hold, byte mapping) and the back end (shift-add conversion, clamp, output register), so
// the request side keeps accepting while a finished result waits; the rate is one pixel per
// clock while rsp_stall is low. Frame width and height are clamped to 2..4096 on use and
// go in via the csr port; the user writes them only while the block is idle (not enforced).
module yuv420sp_to_argb_converter (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [7:0]                           req_luma_byte,
   input  logic [7:0]                           req_blue_diff_byte,
   input  logic [7:0]                           req_red_diff_byte,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [31:0]                          rsp_argb_word,
   output logic                                 rsp_row_end,
   output logic                                 rsp_frame_end,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [yuvc_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [yuvc_pkg::DIM_WIDTH-1:0]       csr_data
);

   yuvc_pkg::link_type push_link;
   yuvc_pkg::link_type pop_link;
   yuvc_pkg::item_type push_item;
   yuvc_pkg::item_type pop_item;
   logic               push_valid;
   logic               pop_ready;

   yuvc_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_luma_byte      (req_luma_byte),
      .req_blue_diff_byte (req_blue_diff_byte),
      .req_red_diff_byte  (req_red_diff_byte),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .push_link_in       (push_link),
      .push_valid         (push_valid),
      .push_item          (push_item)
   );

   yuvc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_link  (push_link),
      .pop_link   (pop_link),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   yuvc_back u_back (
      .clock         (clock),
      .reset         (reset),
      .pop_link      (pop_link),
      .pop_item      (pop_item),
      .pop_ready     (pop_ready),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_argb_word (rsp_argb_word),
      .rsp_row_end   (rsp_row_end),
      .rsp_frame_end (rsp_frame_end)
   );

endmodule

FILE: src/yuvc_checker.sv
// Port-level checks for the converter, bound to its top level.
module yuvc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_argb_word,
   input logic        rsp_row_end,
   input logic        rsp_frame_end
);

   // The output register is empty on the cycle after reset.
   assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result valid straight after reset");

   // Every word is opaque.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_argb_word[31:24] == 8'hFF))
      else $error("alpha byte is not opaque");

   // The last pixel of a frame is also the last of its row.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_frame_end) |-> rsp_row_end)
      else $error("frame end without row end");

   // With the output register empty the queue cannot be full.
   assert property (@(posedge clock) disable iff (reset) !rsp_valid |-> !req_stall)
      else $error("request stalled while no result is pending");

   // A stalled result transaction holds its word.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_argb_word)))
      else $error("stalled result changed");

endmodule

bind yuv420sp_to_argb_converter yuvc_checker u_checker (
   .clock         (clock),
   .reset         (reset),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_argb_word (rsp_argb_word),
   .rsp_row_end   (rsp_row_end),
   .rsp_frame_end (rsp_frame_end)
);
